// ===== rtl/mrb_pkg.sv =====
// Shared constants, codes and control types for the modal resonator bank.
`default_nettype none
package mrb_pkg;

  // Bank size and field widths
  localparam int MODES   = 4096;
  localparam int MODE_W  = 12;
  localparam int CNT_W   = MODE_W + 1;
  localparam int COEF_W  = 32;
  localparam int SMP_W   = 16;
  localparam int GAIN_W  = 24;
  localparam int TDATA_W = 64;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Arithmetic widths
  localparam int PROD_W  = 2 * COEF_W;
  localparam int P3_W    = COEF_W + SMP_W;
  localparam int ACC_W   = PROD_W + MODE_W;
  localparam int CHUNK_W = 32;
  localparam int TOP_W   = ACC_W - 2 * CHUNK_W;
  localparam int MPROD_W = CHUNK_W + GAIN_W + 2;
  localparam int FIN_W   = ACC_W + GAIN_W;
  localparam int OUT_LSB = 24;
  localparam int OUT_MSB = OUT_LSB + SMP_W - 1;

  // Item kinds
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Coefficient selects
  localparam logic [1:0] CSEL_POS  = 2'd0;
  localparam logic [1:0] CSEL_PREV = 2'd1;
  localparam logic [1:0] CSEL_IN   = 2'd2;
  localparam logic [1:0] CSEL_OUT  = 2'd3;

  // Output gain multiply chunk selects, most significant first
  localparam logic [1:0] MSEL_TOP = 2'd0;
  localparam logic [1:0] MSEL_MID = 2'd1;
  localparam logic [1:0] MSEL_LOW = 2'd2;

  // Register indexes (paddr bit 2)
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  localparam logic [CNT_W-1:0]  ACTIVE_RST = CNT_W'(MODES);
  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(1000000);

  typedef struct packed {
    logic              load_we;
    logic              sample_start;
    logic              issue;
    logic [MODE_W-1:0] mode;
    logic              fresh;
    logic              mul_go;
    logic [1:0]        mul_sel;
    logic              out_load;
  } mrb_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mrb_stat_t;

endpackage
`default_nettype wire

// ===== rtl/modal_resonator_bank_unit.sv =====
// Top level: modal resonator bank with stream ports and APB configuration.
// Load request: one per cycle while idle, no result. Sample request, n = min(active_modes, 4096):
// n mode issues, a drain of the MAC pipeline, a 3-step gain multiply, a wait and an emit step;
// with no active modes there are no issues and no drain.
// The next request can be taken once the result is valid; a stalled result holds the emit step.
// Reset restores register defaults and reads all positions as zero via a high-water mark.
`default_nettype none
module modal_resonator_bank_unit import mrb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // s_axis_tdata: mode_index[11:0], coeff_select[13:12], coeff_value[45:14],
  //               excitation[61:46], zero[63:62]
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  // s_axis_tuser: func[0]
  input  wire logic               s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // m_axis_tdata: audio_sample[15:0]
  output logic      [SMP_W-1:0]   m_axis_tdata,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  logic [CNT_W-1:0]  active_modes;
  logic [GAIN_W-1:0] output_gain;
  mrb_cmd_t          cmd;
  mrb_stat_t         stat;

  mrb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .active_modes (active_modes),
    .output_gain  (output_gain)
  );

  mrb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_func      (s_axis_tuser),
    .active_modes (active_modes),
    .stat         (stat),
    .in_ready     (s_axis_tready),
    .cmd          (cmd)
  );

  mrb_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode_index   (s_axis_tdata[11:0]),
    .coeff_select (s_axis_tdata[13:12]),
    .coeff_value  (s_axis_tdata[45:14]),
    .excitation   (s_axis_tdata[61:46]),
    .output_gain  (output_gain),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .audio_sample (m_axis_tdata),
    .stat         (stat)
  );

endmodule
`default_nettype wire

// ===== rtl/mrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read one word each cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/mrb_regs.sv =====
// APB register file: active mode count and output gain.
`default_nettype none
module mrb_regs import mrb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [CNT_W-1:0]  active_modes,
  output logic      [GAIN_W-1:0] output_gain
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Hold registers, update on a completed write
  always_ff @(posedge clk) begin
    if (rst) begin
      active_modes <= ACTIVE_RST;
      output_gain  <= GAIN_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_ACTIVE: active_modes <= pwdata[CNT_W-1:0];
        REG_GAIN:   output_gain  <= pwdata[GAIN_W-1:0];
        default:    active_modes <= active_modes;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE: prdata = DATA_W'(active_modes);
      REG_GAIN:   prdata = DATA_W'(output_gain);
      default:    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mrb_ctrl.sv =====
// Controller: accepts requests, walks active modes, sequences the gain multiply.
`default_nettype none
module mrb_ctrl import mrb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_func,
  input  wire logic [CNT_W-1:0] active_modes,
  input  wire mrb_stat_t        stat,
  output logic                  in_ready,
  output mrb_cmd_t              cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_MUL,
    S_MWAIT,
    S_EMIT
  } state_t;

  state_t            state;
  logic [MODE_W-1:0] mode_cnt;
  logic [1:0]        step;
  logic [CNT_W-1:0]  hw;
  logic [CNT_W-1:0]  n_eff;
  logic              accept;
  logic              last_mode;

  // Clamp the active count to the bank size
  assign n_eff = (active_modes > CNT_W'(MODES)) ? CNT_W'(MODES) : active_modes;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_mode = ({1'b0, mode_cnt} == (n_eff - CNT_W'(1)));

  // Drive datapath commands
  always_comb begin
    cmd.load_we      = accept && (in_func == FUNC_LOAD);
    cmd.sample_start = accept && (in_func == FUNC_SAMPLE);
    cmd.issue        = (state == S_RUN);
    cmd.mode         = mode_cnt;
    // Modes at or above the high-water mark were never updated: read as zero
    cmd.fresh        = ({1'b0, mode_cnt} >= hw);
    cmd.mul_go       = (state == S_MUL);
    cmd.mul_sel      = step;
    cmd.out_load     = (state == S_EMIT) && stat.out_free;
  end

  // Advance state, mode counter, multiply step and high-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode_cnt <= '0;
      step     <= MSEL_TOP;
      hw       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (in_func == FUNC_SAMPLE)) begin
            mode_cnt <= '0;
            step     <= MSEL_TOP;
            state    <= (n_eff == '0) ? S_MUL : S_RUN;
          end
        end
        S_RUN: begin
          mode_cnt <= mode_cnt + MODE_W'(1);
          if (last_mode) begin
            if (n_eff > hw) begin
              hw <= n_eff;
            end
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            step  <= MSEL_TOP;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + 2'd1;
          if (step == MSEL_LOW) begin
            state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mrb_dpath.sv =====
// Datapath: coefficient and position memories, resonator MAC pipeline, output scaling.
`default_nettype none
module mrb_dpath import mrb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mrb_cmd_t          cmd,
  input  wire logic [MODE_W-1:0] mode_index,
  input  wire logic [1:0]        coeff_select,
  input  wire logic [COEF_W-1:0] coeff_value,
  input  wire logic [SMP_W-1:0]  excitation,
  input  wire logic [GAIN_W-1:0] output_gain,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic      [SMP_W-1:0]  audio_sample,
  output mrb_stat_t              stat
);

  // Coefficient memories, one per select
  logic [COEF_W-1:0]   c_rd [4];
  logic [2*COEF_W-1:0] mode_rd;

  for (genvar k = 0; k < 4; k++) begin : g_coef
    mrb_ram #(.WIDTH(COEF_W), .DEPTH(MODES)) u_coef (
      .clk   (clk),
      .we    (cmd.load_we && (coeff_select == 2'(k))),
      .waddr (mode_index),
      .wdata (coeff_value),
      .raddr (cmd.mode),
      .rdata (c_rd[k])
    );
  end

  // Position memory holds {previous, current} per mode
  logic                v3;
  logic [MODE_W-1:0]   m3;
  logic signed [COEF_W-1:0] next3;
  logic signed [COEF_W-1:0] pos3;

  mrb_ram #(.WIDTH(2*COEF_W), .DEPTH(MODES)) u_mode (
    .clk   (clk),
    .we    (v3),
    .waddr (m3),
    .wdata ({pos3, next3}),
    .raddr (cmd.mode),
    .rdata (mode_rd)
  );

  // Latch the excitation of the current sample
  logic signed [SMP_W-1:0] u;
  always_ff @(posedge clk) begin
    if (cmd.sample_start) begin
      u <= excitation;
    end
  end

  // Stage 1: read data arrives
  logic              v1;
  logic [MODE_W-1:0] m1;
  logic              z1;
  logic signed [COEF_W-1:0] pos_e;
  logic signed [COEF_W-1:0] prev_e;
  logic signed [COEF_W-1:0] c1_s;
  logic signed [COEF_W-1:0] c2_s;
  logic signed [COEF_W-1:0] c3_s;

  assign pos_e  = z1 ? '0 : mode_rd[COEF_W-1:0];
  assign prev_e = z1 ? '0 : mode_rd[2*COEF_W-1:COEF_W];
  assign c1_s   = c_rd[CSEL_POS];
  assign c2_s   = c_rd[CSEL_PREV];
  assign c3_s   = c_rd[CSEL_IN];

  // Stage 2: three products
  logic              v2;
  logic [MODE_W-1:0] m2;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;
  logic signed [P3_W-1:0]   p3;
  logic signed [COEF_W-1:0] mo2;
  logic signed [COEF_W-1:0] pos2;

  // Stage 3: new position
  logic signed [PROD_W-1:0] sum;
  logic signed [COEF_W-1:0] mo3;

  assign sum = p1 + p2 + (PROD_W'(p3) <<< 8);

  // Stage 4: output product, then accumulate
  logic                     v4;
  logic signed [PROD_W-1:0] q4;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    m1   <= cmd.mode;
    z1   <= cmd.fresh;
    m2   <= m1;
    p1   <= c1_s * pos_e;
    p2   <= c2_s * prev_e;
    p3   <= c3_s * u;
    mo2  <= c_rd[CSEL_OUT];
    pos2 <= pos_e;
    m3    <= m2;
    next3 <= sum[COEF_W+15:16];
    mo3   <= mo2;
    pos3  <= pos2;
    q4    <= next3 * mo3;
  end

  // Clear at sample start, add each mode's output
  always_ff @(posedge clk) begin
    if (cmd.sample_start) begin
      acc <= '0;
    end else if (v4) begin
      acc <= acc + ACC_W'(q4);
    end
  end

  assign stat.pipe_busy = v1 || v2 || v3 || v4;

  // Gain multiply: one chunk of the accumulator per step, top chunk first
  logic signed [CHUNK_W:0]    chunk;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [MPROD_W-1:0]  mprod;
  logic                       pv;
  logic                       pfirst;
  logic signed [FIN_W-1:0]    fin;

  assign gain_s = {1'b0, output_gain};

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_TOP: chunk = (CHUNK_W+1)'($signed(acc[ACC_W-1:2*CHUNK_W]));
      MSEL_MID: chunk = {1'b0, acc[2*CHUNK_W-1:CHUNK_W]};
      MSEL_LOW: chunk = {1'b0, acc[CHUNK_W-1:0]};
      default:  chunk = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    mprod  <= chunk * gain_s;
    pfirst <= (cmd.mul_sel == MSEL_TOP);
    if (pv) begin
      fin <= (pfirst ? '0 : (fin <<< CHUNK_W)) + FIN_W'(mprod);
    end
  end

  // Saturate to Q8.8
  logic [FIN_W-OUT_MSB-1:0] fin_top;
  logic [SMP_W-1:0]         sat;

  assign fin_top = fin[FIN_W-1:OUT_MSB];

  always_comb begin
    if ((&fin_top) || !(|fin_top)) begin
      sat = fin[OUT_MSB:OUT_LSB];
    end else if (fin[FIN_W-1]) begin
      sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  // Output register: hold until taken
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      audio_sample <= sat;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mrb_checker.sv =====
// Port-level checks for the modal resonator bank, bound to the top level.
`default_nettype none
module mrb_checker import mrb_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic               s_axis_tuser,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [SMP_W-1:0]   m_axis_tdata
);

  // Reset leaves the block ready with no result pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("block not idle after reset");

  // A sample request occupies the block for at least the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_SAMPLE)) |=> !s_axis_tready)
    else $error("request taken while a sample is in progress");

  // A load request taken while no result is pending is not followed by a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD) && !m_axis_tvalid)
    |=> !m_axis_tvalid)
    else $error("result appeared after a load request");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind modal_resonator_bank_unit mrb_checker u_mrb_checker (.*);
`default_nettype wire
